// ===== sv/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths and default operand width shared by the exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Width of every numeric field on the ports (base, exponent, modulus, result)
    localparam int unsigned DATA_BITS = 64;

    // Default operand width; operands are taken in their low WORD_BITS bits
    localparam int unsigned WORD_BITS_DEFAULT = 64;

endpackage

// ===== sv/modular_exponentiation_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation, left-to-right square-and-multiply
// Computes base^exponent mod modulus with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Sequence: special cases (bad modulus, zero base or zero exponent) go straight
//   to FINISH. Otherwise the exponent is scanned for its top set bit, the base
//   is reduced mod p, and each lower exponent bit takes a square, plus a
//   multiply by the reduced base when that bit is set.
// Throughput: one item at a time; the multiplier takes one multiplier bit per
//   cycle.
// Reset: synchronous, active low; clears the FSM, the output valid and the
//   modulus register (modulus 0, so every item is an error until written).
// ----------------------------------------------------------------------------
module modular_exponentiation_64 #(
    parameter int unsigned WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration: modulus
    input  logic                                cfg_we,
    input  logic [modexp_pkg::DATA_BITS-1:0]    cfg_wdata,
    // Input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*modexp_pkg::DATA_BITS-1:0]  s_tdata,   // [63:0] base, [127:64] exponent
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [modexp_pkg::DATA_BITS-1:0]    m_tdata,   // [63:0] result
    output logic                                m_tuser    // [0] error
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned DB = modexp_pkg::DATA_BITS;
    localparam int unsigned CW = $clog2(W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REDUCE,
        ST_NEXT,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [W-1:0]    modulus_reg, modulus_next;
    logic [W-1:0]    p_reg, p_next;        // modulus captured for the current item
    logic [W-1:0]    e_reg, e_next;        // exponent shift register, MSB first
    logic [CW-1:0]   ecnt_reg, ecnt_next;  // exponent bits still to process
    logic [W-1:0]    acc_reg, acc_next;    // multiplier accumulator
    logic [W-1:0]    x_reg, x_next;        // multiplicand
    logic [W-1:0]    y_reg, y_next;        // multiplier shift register, MSB first
    logic [CW-1:0]   mcnt_reg, mcnt_next;  // multiplier bits left after this one
    logic [W-1:0]    ar_reg, ar_next;      // base reduced mod p
    logic [W-1:0]    prod_reg, prod_next;  // running power / final result
    logic            err_reg, err_next;
    logic            ovalid_reg, ovalid_next;
    logic [W-1:0]    res_reg, res_next;
    logic            rerr_reg, rerr_next;

    logic [W-1:0]    in_base, in_exp, in_p;
    logic            in_err, in_zero, in_one;

    // One multiplier step: acc = 2*acc mod p, then + x mod p if the bit is set
    logic [W:0]      dbl_sum, add_sum;
    logic [W-1:0]    dbl_red, step_val;

    assign in_base = s_tdata[W-1:0];
    assign in_exp  = s_tdata[DB+W-1:DB];
    assign in_p    = modulus_reg;
    assign in_err  = (in_p <= W'(1)) || ((in_base == '0) && (in_exp == '0));
    assign in_zero = (in_base == '0);
    assign in_one  = (in_exp == '0);

    always_comb begin
        dbl_sum = {acc_reg, 1'b0};
        dbl_red = (dbl_sum >= {1'b0, p_reg}) ? W'(dbl_sum - {1'b0, p_reg}) : dbl_sum[W-1:0];
        add_sum = {1'b0, dbl_red} + {1'b0, x_reg};
        if (y_reg[W-1]) begin
            step_val = (add_sum >= {1'b0, p_reg}) ? W'(add_sum - {1'b0, p_reg})
                                                  : add_sum[W-1:0];
        end else begin
            step_val = dbl_red;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = DB'(res_reg);
    assign m_tuser  = rerr_reg;

    always_comb begin
        state_next   = state_reg;
        modulus_next = modulus_reg;
        p_next       = p_reg;
        e_next       = e_reg;
        ecnt_next    = ecnt_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        mcnt_next    = mcnt_reg;
        ar_next      = ar_reg;
        prod_next    = prod_reg;
        err_next     = err_reg;
        res_next     = res_reg;
        rerr_next    = rerr_reg;
        // Drop the held result once it transfers
        ovalid_next  = ovalid_reg && !m_tready;

        if (cfg_we) begin
            modulus_next = cfg_wdata[W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    p_next    = in_p;
                    e_next    = in_exp;
                    ecnt_next = CW'(W - 1);
                    // Reduce the base first: 1 * base mod p on the multiplier
                    x_next    = W'(1);
                    y_next    = in_base;
                    acc_next  = '0;
                    mcnt_next = CW'(W - 1);
                    err_next  = in_err;
                    if (in_err || in_zero) begin
                        prod_next  = '0;
                        state_next = ST_FINISH;
                    end else if (in_one) begin
                        prod_next  = W'(1);
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Shift out leading zeros; the top set bit itself is consumed too
                e_next = e_reg << 1;
                if (e_reg[W-1]) begin
                    state_next = ST_REDUCE;
                end else begin
                    ecnt_next = ecnt_reg - CW'(1);
                end
            end
            ST_REDUCE: begin
                acc_next  = step_val;
                y_next    = y_reg << 1;
                mcnt_next = mcnt_reg - CW'(1);
                if (mcnt_reg == '0) begin
                    ar_next    = step_val;
                    prod_next  = step_val;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (ecnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    ecnt_next  = ecnt_reg - CW'(1);
                    x_next     = prod_reg;
                    y_next     = prod_reg;
                    acc_next   = '0;
                    mcnt_next  = CW'(W - 1);
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                acc_next  = step_val;
                y_next    = y_reg << 1;
                mcnt_next = mcnt_reg - CW'(1);
                if (mcnt_reg == '0) begin
                    prod_next = step_val;
                    if (e_reg[W-1]) begin
                        x_next     = ar_reg;
                        y_next     = step_val;
                        acc_next   = '0;
                        mcnt_next  = CW'(W - 1);
                        state_next = ST_MULT;
                    end else begin
                        e_next     = e_reg << 1;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_MULT: begin
                acc_next  = step_val;
                y_next    = y_reg << 1;
                mcnt_next = mcnt_reg - CW'(1);
                if (mcnt_reg == '0) begin
                    prod_next  = step_val;
                    e_next     = e_reg << 1;
                    state_next = ST_NEXT;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (!ovalid_reg || m_tready) begin
                    res_next    = prod_reg;
                    rerr_next   = err_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        e_reg    <= e_next;
        ecnt_reg <= ecnt_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        mcnt_reg <= mcnt_next;
        ar_reg   <= ar_next;
        prod_reg <= prod_next;
        err_reg  <= err_next;
        res_reg  <= res_next;
        rerr_reg <= rerr_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            modulus_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            modulus_reg <= modulus_next;
        end
    end

    // An error result always carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result with nonzero data");

    // A good result is reduced below the modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (res_reg < modulus_reg))
        else $error("result not below modulus");

    // The accumulator stays reduced while the multiplier runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_REDUCE) || (state_reg == ST_SQUARE) || (state_reg == ST_MULT))
        |-> (acc_reg < p_reg))
        else $error("multiplier accumulator out of range");

    // The scan only runs on a nonzero exponent, so it always terminates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (e_reg != '0))
        else $error("exponent scan on zero exponent");

    // A finished item is loaded into the output register in the cycle it leaves FINISH
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && (state_next == ST_IDLE)) |=> m_tvalid)
        else $error("finished item not presented");

endmodule

// ===== tb/sv/modular_exponentiation_64_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for modular_exponentiation_64
// Writes a series of moduli and sends (base, exponent) transfers to the block.
// An in-bench model of base^exponent mod p predicts each result that is not typed
// in, and every result transfer is compared against the oldest prediction. Both channels
// idle at random, apart from one phase that runs with no idling at all.
// ----------------------------------------------------------------------------
module modular_exponentiation_64_test;

    localparam int unsigned DW          = modexp_pkg::DATA_BITS;
    // Budget for about 100 full-width exponent items with stalls, several times over.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned ROW_COUNT   = 25;
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_ITEMS = 10;

    localparam logic [DW-1:0] ALL_ONES  = {DW{1'b1}};
    localparam logic [DW-1:0] TOP_BIT   = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64 - 59

    // Expected content of one result transfer
    typedef struct packed {
        logic [DW-1:0] value;
        logic          error;
    } residue_t;

    typedef enum logic {
        ROW_MODULUS,
        ROW_ITEM
    } row_kind_t;

    // One row of the directed part. For ROW_MODULUS, first holds the modulus.
    typedef struct packed {
        row_kind_t     kind;
        logic [DW-1:0] first;
        logic [DW-1:0] second;
        logic          known;
        residue_t      want;
    } vector_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [DW-1:0]     cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [2*DW-1:0]   s_tdata   = '0;    // [63:0] base, [127:64] exponent
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DW-1:0]     m_tdata;           // [63:0] result
    logic              m_tuser;           // [0] error

    // Local copy of the modulus register, updated with every write
    logic [DW-1:0]     modulus_copy = '0;
    residue_t          pending_powers[$];
    int unsigned       fault_count  = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       result_count = 0;
    // Set while both sides run without idling
    bit                calm         = 1'b0;

    modular_exponentiation_64 i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: left-to-right square-and-multiply. Products are formed at
    // double width and reduced directly, which must match the block's
    // interleaved shift-and-add reduction.
    // ------------------------------------------------------------------------
    function automatic residue_t power_mod(logic [DW-1:0] base, logic [DW-1:0] expo,
                                           logic [DW-1:0] p);
        logic [2*DW-1:0] acc;
        logic [2*DW-1:0] base_r;
        logic [2*DW-1:0] wide_p;
        int              top;
        int              i;
        residue_t        res;
        res = '{value: '0, error: 1'b0};
        // Bad modulus, or the undefined 0^0
        if (p <= 1 || (base == 0 && expo == 0)) begin
            res.error = 1'b1;
            return res;
        end
        if (base == 0) begin
            return res;
        end
        if (expo == 0) begin
            res.value = DW'(1);
            return res;
        end
        wide_p = {{DW{1'b0}}, p};
        base_r = {{DW{1'b0}}, base} % wide_p;
        acc    = base_r;
        top    = DW - 1;
        while (top > 0 && !expo[top]) top--;
        for (i = top - 1; i >= 0; i--) begin
            acc = (acc * acc) % wide_p;
            if (expo[i]) acc = (acc * base_r) % wide_p;
        end
        res.value = acc[DW-1:0];
        return res;
    endfunction

    function automatic logic [DW-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("MISMATCH at cycle %0d, result %0d: %s got %h want %h",
                 cycle_count, result_count, what, got, want);
        fault_count++;
    endtask

    // ------------------------------------------------------------------------
    // Drive one input transfer. Entered and left at a falling edge; tvalid is
    // left high so the next call can present its item in the same step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [DW-1:0] base, input logic [DW-1:0] expo,
                             input logic known, input residue_t want);
        // Idle the sender for a random number of cycles, except in the calm phase
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {expo, base};
        do @(posedge aclk); while (!s_tready);
        // Transfer taken at this edge: record what it must produce
        pending_powers.push_back(known ? want : power_mod(base, expo, modulus_copy));
        @(negedge aclk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write the modulus only with the block idle
    task automatic set_modulus(input logic [DW-1:0] value);
        drain_results();
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we       <= 1'b0;
        modulus_copy  = value;
    endtask

    // Receiver: stall at random except during the calm phase
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        residue_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_powers.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = pending_powers.pop_front();
                if (m_tdata !== want.value) report_mismatch("result", m_tdata, want.value);
                if (m_tuser !== want.error) begin
                    report_mismatch("error flag", {{(DW-1){1'b0}}, m_tuser},
                                    {{(DW-1){1'b0}}, want.error});
                end
            end
        end
    end

    // Timeout: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modular_exponentiation_64_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed rows: special cases first, then the extremes of the modulus.
    // Expected values are typed in where they are obvious; the rest go
    // through the predictor.
    // ------------------------------------------------------------------------
    localparam vector_t DIRECTED_ROWS[ROW_COUNT] = '{
        // Modulus still 0 after reset: everything is an error
        '{ROW_ITEM,    64'd5,      64'd3,      1'b1, '{64'd0, 1'b1}},
        '{ROW_ITEM,    64'd0,      64'd0,      1'b1, '{64'd0, 1'b1}},
        '{ROW_MODULUS, 64'd1,      64'd0,      1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    ALL_ONES,   ALL_ONES,   1'b1, '{64'd0, 1'b1}},
        '{ROW_MODULUS, ALL_ONES,   64'd0,      1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd0,      64'd0,      1'b1, '{64'd0, 1'b1}},
        '{ROW_ITEM,    64'd0,      64'd5,      1'b1, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd7,      64'd0,      1'b1, '{64'd1, 1'b0}},
        // Base equal to the modulus reduces to zero
        '{ROW_ITEM,    ALL_ONES,   64'd1,      1'b1, '{64'd0, 1'b0}},
        '{ROW_ITEM,    ALL_ONES-1, 64'd2,      1'b1, '{64'd1, 1'b0}},
        '{ROW_ITEM,    64'd2,      64'd63,     1'b1, '{TOP_BIT, 1'b0}},
        '{ROW_ITEM,    64'd3,      ALL_ONES,   1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd1,      ALL_ONES,   1'b1, '{64'd1, 1'b0}},
        // Smallest legal modulus
        '{ROW_MODULUS, 64'd2,      64'd0,      1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd3,      64'd5,      1'b1, '{64'd1, 1'b0}},
        '{ROW_ITEM,    64'd2,      64'd7,      1'b1, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd0,      ALL_ONES,   1'b1, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd5,      64'd0,      1'b1, '{64'd1, 1'b0}},
        // Large prime modulus
        '{ROW_MODULUS, BIG_PRIME,  64'd0,      1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                                               1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    BIG_PRIME-1, TOP_BIT,   1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    ALL_ONES,   ALL_ONES,   1'b0, '{64'd0, 1'b0}},
        '{ROW_MODULUS, 64'd3,      64'd0,      1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                               1'b0, '{64'd0, 1'b0}},
        '{ROW_ITEM,    64'd2,      64'd1,      1'b1, '{64'd2, 1'b0}}
    };

    initial begin
        logic [DW-1:0] base;
        logic [DW-1:0] expo;
        logic [DW-1:0] p;
        int unsigned   pick;
        int unsigned   w;

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_MODULUS) begin
                set_modulus(DIRECTED_ROWS[r].first);
            end else begin
                send_item(DIRECTED_ROWS[r].first, DIRECTED_ROWS[r].second,
                          DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
            end
        end

        // --------------------------------------------------------------------
        // Random phases: a new modulus per phase, then a burst of items
        // --------------------------------------------------------------------
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph) inside
                1:       p = DW'($urandom_range(2, 50));
                3:       p = ALL_ONES;
                4:       p = {32'd0, $urandom} | 64'd2;
                5:       p = DW'($urandom_range(0, 1));
                0, 7:    p = rand_word() | TOP_BIT;
                default: p = rand_word();
            endcase
            set_modulus(p);
            // Phase 1 runs with no idling on either side
            calm = (ph == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 15);
                base = rand_word();
                if (pick == 0) base = '0;
                else if (pick < 4) base = {32'd0, $urandom};
                // Mostly short exponents keep the run short; a few span the word
                if (pick == 4) begin
                    expo = '0;
                end else if ($urandom_range(0, 7) == 0) begin
                    expo = rand_word() | TOP_BIT;
                end else begin
                    w    = $urandom_range(1, 20);
                    expo = rand_word() >> (DW - w);
                end
                send_item(base, expo, 1'b0, '{value: '0, error: 1'b0});
                // Hold the sender once, mid-way through phase 4, until the block is empty
                if (ph == 4 && k == PHASE_ITEMS / 2) drain_results();
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (pending_powers.size() != 0) begin
            report_mismatch("results missing", DW'(pending_powers.size()), '0);
        end
        if (fault_count == 0) begin
            $display("modular_exponentiation_64_test: clean");
        end else begin
            $display("modular_exponentiation_64_test: errors");
        end
        $finish;
    end

endmodule
